/* design/i2cmbe_pkg.sv */
// Shared types and constants of the I2C master byte engine.
package i2cmbe_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [7:0] MSB_MASK          = 8'h80;

   // operation codes on the request channel
   typedef enum logic [2:0] {
      OP_START    = 3'd0,
      OP_STOP     = 3'd1,
      OP_WRITE    = 3'd2,
      OP_READ     = 3'd3,
      OP_WAIT_ACK = 3'd4
   } op_code_type;

   // command class after decode; CMD_NONE covers no command and unused codes
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ,
      CMD_WAIT_ACK
   } cmd_kind_type;

   // register index on the configuration port
   typedef enum logic {
      REG_HALF_PERIOD = 1'b0,
      REG_ACK_TIMEOUT = 1'b1
   } reg_index_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   tx_byte;
      logic         send_ack;
      logic         sda_in;
   } tick_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* design/i2cmbe_req_if.sv */
// Request channel: one bus tick with an optional command.
interface i2cmbe_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] operation;
   logic [7:0] tx_byte;
   logic       send_ack;
   logic       sda_in;

   modport source (
      output valid, cmd_valid, operation, tx_byte, send_ack, sda_in,
      input  ready
   );
   modport sink (
      input  valid, cmd_valid, operation, tx_byte, send_ack, sda_in,
      output ready
   );
endinterface

/* design/i2cmbe_rsp_if.sv */
// Response channel: pin levels and status for one bus tick.
interface i2cmbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       sda_drive;
   logic       ready_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_error;

   modport source (
      output valid, scl_out, sda_out, sda_drive, ready_res, done_res, rx_byte, ack_error,
      input  ready
   );
   modport sink (
      input  valid, scl_out, sda_out, sda_drive, ready_res, done_res, rx_byte, ack_error,
      output ready
   );
endinterface

/* design/i2c_master_byte_engine_core.sv */
// I2C master byte engine top level: configuration registers, front end, queue, sequencer.
//
// Each request transfer is one tick of bus time and yields exactly one response transfer
// with the pin levels and status after that tick. The block takes one request per clock
// cycle while the queue is not full; each tick passes a queue entry, then the response
// register. The sequencer advances the bus phase machine by one tick per cycle while
// an item is queued and the response slot is free. A small queue between the request
// decoder and the sequencer absorbs response stalls; request ready drops only when it is
// full. The user must write half_period (offset 0x0) and ack_timeout (offset 0x4) over
// the APB port only while no ticks are in flight; the block does not enforce this.
module i2c_master_byte_engine_core #(
   parameter int QUEUE_DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   i2cmbe_req_if.sink  req_bus,
   i2cmbe_rsp_if.source rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] half_period_ff;
   logic [7:0] ack_timeout_ff;
   logic       csr_write;

   i2cmbe_pkg::queue_status_type q_status;
   i2cmbe_pkg::tick_item_type    push_item;
   i2cmbe_pkg::tick_item_type    pop_item;
   logic                         push;
   logic                         pop;
   logic                         track_overflow;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= i2cmbe_pkg::HALF_PERIOD_RESET;
         ack_timeout_ff <= i2cmbe_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            i2cmbe_pkg::REG_HALF_PERIOD: half_period_ff <= csr_pwdata[7:0];
            i2cmbe_pkg::REG_ACK_TIMEOUT: ack_timeout_ff <= csr_pwdata[7:0];
            default:                     half_period_ff <= half_period_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         i2cmbe_pkg::REG_HALF_PERIOD: csr_prdata = {24'd0, half_period_ff};
         i2cmbe_pkg::REG_ACK_TIMEOUT: csr_prdata = {24'd0, ack_timeout_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   i2cmbe_front u_front (
      .req_bus   (req_bus),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   i2cmbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   i2cmbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_period_ff),
      .ack_timeout (ack_timeout_ff),
      .q_status    (q_status),
      .item        (pop_item),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

   i2cmbe_track #(
      .DEPTH (QUEUE_DEPTH)
   ) u_track (
      .clock    (clock),
      .reset    (reset),
      .in_xfer  (req_bus.valid && req_bus.ready),
      .out_xfer (rsp_bus.valid && rsp_bus.ready),
      .overflow (track_overflow)
   );

   a_done_means_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.done_res |-> rsp_bus.ready_res)
      else $error("done pulse while sequencer not idle");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("queue popped while empty");

   a_half_period_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_paddr[2] == i2cmbe_pkg::REG_HALF_PERIOD)
      |=> half_period_ff == $past(csr_pwdata[7:0]))
      else $error("half_period register not updated");

   a_no_lost_ticks: assert property (@(posedge clock) disable iff (reset)
      !track_overflow)
      else $error("more ticks in flight than storage holds");

endmodule

/* design/i2cmbe_front.sv */
// Front end: takes request transfers and classifies the command of each tick.
module i2cmbe_front (
   i2cmbe_req_if.sink                 req_bus,
   input  i2cmbe_pkg::queue_status_type q_status,
   output logic                       push,
   output i2cmbe_pkg::tick_item_type  push_item
);

   i2cmbe_pkg::cmd_kind_type kind;

   always_comb begin
      kind = i2cmbe_pkg::CMD_NONE;
      if (req_bus.cmd_valid) begin
         case (req_bus.operation)
            i2cmbe_pkg::OP_START:    kind = i2cmbe_pkg::CMD_START;
            i2cmbe_pkg::OP_STOP:     kind = i2cmbe_pkg::CMD_STOP;
            i2cmbe_pkg::OP_WRITE:    kind = i2cmbe_pkg::CMD_WRITE;
            i2cmbe_pkg::OP_READ:     kind = i2cmbe_pkg::CMD_READ;
            i2cmbe_pkg::OP_WAIT_ACK: kind = i2cmbe_pkg::CMD_WAIT_ACK;
            default:                 kind = i2cmbe_pkg::CMD_NONE;
         endcase
      end
   end

   assign req_bus.ready      = !q_status.full;
   assign push               = req_bus.valid && !q_status.full;
   assign push_item.kind     = kind;
   assign push_item.tx_byte  = req_bus.tx_byte;
   assign push_item.send_ack = req_bus.send_ack;
   assign push_item.sda_in   = req_bus.sda_in;

endmodule

/* design/i2cmbe_queue.sv */
// Short queue of classified ticks between front end and bus sequencer.
module i2cmbe_queue #(
   parameter int DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  i2cmbe_pkg::tick_item_type   push_item,
   input  logic                        pop,
   output i2cmbe_pkg::tick_item_type   pop_item,
   output i2cmbe_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   i2cmbe_pkg::tick_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* design/i2cmbe_back.sv */
// Bus sequencer: advances the SCL/SDA phase machine one tick per queued item.
module i2cmbe_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [7:0]                   half_period,
   input  logic [7:0]                   ack_timeout,
   input  i2cmbe_pkg::queue_status_type q_status,
   input  i2cmbe_pkg::tick_item_type    item,
   output logic                         pop,
   i2cmbe_rsp_if.source                 rsp_bus
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_SP_C,
      PH_WR_D, PH_WR_H, PH_WR_L, PH_RD_L, PH_RD_H, PH_AK_L, PH_AK_H,
      PH_WA_A, PH_WA_H, PH_WA_P, PH_WA_T
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] delay_ff, delay_in;
   logic [7:0] timeout_ff, timeout_in;
   logic       ack_flag_ff, ack_flag_in;
   logic       error_ff, error_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       drive_ff, drive_in;
   logic [7:0] rx_hold_ff, rx_hold_in;
   logic       done_in;
   logic       out_valid_ff;

   logic [7:0] hp_eff;
   logic [8:0] delay_inc;
   logic       hold_over;
   logic [7:0] delay_after;
   logic [3:0] bit_next;
   logic       step;

   // output slot frees when empty or taken this cycle
   assign step = !q_status.empty && (!out_valid_ff || rsp_bus.ready);
   assign pop  = step;

   assign hp_eff      = (half_period == 8'd0) ? 8'd1 : half_period;
   assign delay_inc   = {1'b0, delay_ff} + 9'd1;
   assign hold_over   = (delay_inc >= {1'b0, hp_eff});
   assign delay_after = hold_over ? 8'd0 : delay_inc[7:0];
   assign bit_next    = bit_index_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      delay_in     = delay_ff;
      timeout_in   = timeout_ff;
      ack_flag_in  = ack_flag_ff;
      error_in     = error_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      drive_in     = drive_ff;
      rx_hold_in   = rx_hold_ff;
      done_in      = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (item.kind != i2cmbe_pkg::CMD_NONE) begin
               bit_index_in = '0;
               delay_in     = '0;
               timeout_in   = '0;
               case (item.kind)
                  i2cmbe_pkg::CMD_START: begin
                     drive_in = 1'b1;
                     sda_in   = 1'b1;
                     scl_in   = 1'b1;
                     phase_in = PH_ST_A;
                  end
                  i2cmbe_pkg::CMD_STOP: begin
                     drive_in = 1'b1;
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     phase_in = PH_SP_A;
                  end
                  i2cmbe_pkg::CMD_WRITE: begin
                     drive_in = 1'b1;
                     sda_in   = (item.tx_byte & i2cmbe_pkg::MSB_MASK) != 8'd0;
                     shift_in = {item.tx_byte[6:0], 1'b0};
                     phase_in = PH_WR_D;
                  end
                  i2cmbe_pkg::CMD_READ: begin
                     ack_flag_in = item.send_ack;
                     drive_in    = 1'b0;
                     scl_in      = 1'b0;
                     shift_in    = '0;
                     phase_in    = PH_RD_L;
                  end
                  i2cmbe_pkg::CMD_WAIT_ACK: begin
                     error_in = 1'b0;
                     drive_in = 1'b0;
                     sda_in   = 1'b1;
                     phase_in = PH_WA_A;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         PH_ST_A: begin
            delay_in = delay_after;
            if (hold_over) begin
               sda_in   = 1'b0;
               phase_in = PH_ST_B;
            end
         end
         PH_ST_B: begin
            delay_in = delay_after;
            if (hold_over) begin
               scl_in   = 1'b0;
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_SP_A: begin
            delay_in = delay_after;
            if (hold_over) begin
               scl_in   = 1'b1;
               phase_in = PH_SP_B;
            end
         end
         PH_SP_B: begin
            delay_in = delay_after;
            if (hold_over) begin
               sda_in   = 1'b1;
               phase_in = PH_SP_C;
            end
         end
         PH_SP_C: begin
            delay_in = delay_after;
            if (hold_over) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_WR_D: begin
            delay_in = delay_after;
            if (hold_over) begin
               scl_in   = 1'b1;
               phase_in = PH_WR_H;
            end
         end
         PH_WR_H: begin
            delay_in = delay_after;
            if (hold_over) begin
               scl_in   = 1'b0;
               phase_in = PH_WR_L;
            end
         end
         PH_WR_L: begin
            delay_in = delay_after;
            if (hold_over) begin
               bit_index_in = bit_next;
               if (bit_next < 4'(i2cmbe_pkg::BITS_PER_BYTE)) begin
                  sda_in   = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
                  phase_in = PH_WR_D;
               end else begin
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_RD_L: begin
            delay_in = delay_after;
            if (hold_over) begin
               // sample on the tick SCL rises
               scl_in   = 1'b1;
               shift_in = {shift_ff[6:0], item.sda_in};
               phase_in = PH_RD_H;
            end
         end
         PH_RD_H: begin
            delay_in = delay_after;
            if (hold_over) begin
               bit_index_in = bit_next;
               scl_in       = 1'b0;
               if (bit_next < 4'(i2cmbe_pkg::BITS_PER_BYTE)) begin
                  phase_in = PH_RD_L;
               end else begin
                  rx_hold_in = shift_ff;
                  drive_in   = 1'b1;
                  sda_in     = !ack_flag_ff;
                  phase_in   = PH_AK_L;
               end
            end
         end
         PH_AK_L: begin
            delay_in = delay_after;
            if (hold_over) begin
               scl_in   = 1'b1;
               phase_in = PH_AK_H;
            end
         end
         PH_AK_H: begin
            delay_in = delay_after;
            if (hold_over) begin
               scl_in   = 1'b0;
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_WA_A: begin
            delay_in = delay_after;
            if (hold_over) begin
               scl_in   = 1'b1;
               phase_in = PH_WA_H;
            end
         end
         PH_WA_H: begin
            delay_in = delay_after;
            if (hold_over) begin
               timeout_in = '0;
               phase_in   = PH_WA_P;
            end
         end
         PH_WA_P: begin
            if (!item.sda_in) begin
               scl_in   = 1'b0;
               delay_in = '0;
               phase_in = PH_WA_T;
            end else if (timeout_ff >= ack_timeout) begin
               // no acknowledge: flag it and release the bus with a stop
               error_in = 1'b1;
               drive_in = 1'b1;
               scl_in   = 1'b0;
               sda_in   = 1'b0;
               delay_in = '0;
               phase_in = PH_SP_A;
            end else begin
               timeout_in = timeout_ff + 8'd1;
            end
         end
         PH_WA_T: begin
            delay_in = delay_after;
            if (hold_over) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         delay_ff     <= '0;
         timeout_ff   <= '0;
         ack_flag_ff  <= 1'b0;
         error_ff     <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         drive_ff     <= 1'b1;
         rx_hold_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff     <= phase_in;
            bit_index_ff <= bit_index_in;
            shift_ff     <= shift_in;
            delay_ff     <= delay_in;
            timeout_ff   <= timeout_in;
            ack_flag_ff  <= ack_flag_in;
            error_ff     <= error_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            drive_ff     <= drive_in;
            rx_hold_ff   <= rx_hold_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_bus.scl_out   <= scl_in;
         rsp_bus.sda_out   <= sda_in;
         rsp_bus.sda_drive <= drive_in;
         rsp_bus.ready_res <= (phase_in == PH_IDLE);
         rsp_bus.done_res  <= done_in;
         rsp_bus.rx_byte   <= rx_hold_in;
         rsp_bus.ack_error <= error_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;

endmodule

/* design/i2cmbe_front_back_note_placeholder.sv */
// Sequencing helper: counts response transfers outstanding against request transfers.
module i2cmbe_track #(
   parameter int DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic in_xfer,
   input  logic out_xfer,
   output logic overflow
);

   // one count above the legal maximum must be representable
   localparam int CNT_W = $clog2(DEPTH + 3);

   logic [CNT_W-1:0] pending_ff, pending_in;

   always_comb begin
      case ({in_xfer, out_xfer})
         2'b10:   pending_in = pending_ff + 1'b1;
         2'b01:   pending_in = pending_ff - 1'b1;
         default: pending_in = pending_ff;
      endcase
   end

   // queue entries plus the response register
   assign overflow = (pending_ff > CNT_W'(DEPTH + 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

endmodule

/* tb/sv/i2c_master_byte_engine_core_tb.sv */
// Self-checking testbench: bus-tick predictor and scoreboard for the I2C master byte engine.
module i2c_master_byte_engine_core_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_MAX     = 4000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_LEN      = 300;

   // operation codes the block must ignore
   localparam logic [2:0] OP_RSVD_5 = 3'd5;
   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   typedef enum logic [4:0] {
      BP_IDLE, BP_START_A, BP_START_B, BP_STOP_A, BP_STOP_B, BP_STOP_C,
      BP_WR_DATA, BP_WR_HIGH, BP_WR_LOW, BP_RD_LOW, BP_RD_HIGH,
      BP_ACK_LOW, BP_ACK_HIGH, BP_WA_ARM, BP_WA_HIGH, BP_WA_POLL, BP_WA_TAIL
   } bus_phase_type;

   // how the slave side drives SDA while a command runs
   typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND, SDA_LATE} sda_mode_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] operation;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } tick_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       drive;
      logic       ready;
      logic       done;
      logic [7:0] rx;
      logic       err;
   } pins_type;

   typedef struct packed {
      logic         cfg;
      logic [7:0]   hp;
      logic [7:0]   at;
      logic         cmd_valid;
      logic [2:0]   op;
      logic [7:0]   tx;
      logic         sack;
      sda_mode_type mode;
      logic         typed;
      pins_type     want;
   } dir_row_type;

   localparam pins_type IDLE_PINS  = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, ready: 1'b1,
                                       done: 1'b0, rx: 8'h00, err: 1'b0};
   localparam pins_type START_PINS = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, ready: 1'b0,
                                       done: 1'b0, rx: 8'h00, err: 1'b0};
   localparam pins_type NO_PINS    = '0;

   localparam int N_ROWS = 24;
   // cfg, half_period, ack_timeout, cmd_valid, op, tx_byte, send_ack, sda, typed, pins
   dir_row_type directed_rows [N_ROWS] = '{
      '{1'b0, 8'd0, 8'd0, 1'b0, i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 1'b1, IDLE_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, OP_RSVD_5, 8'hFF, 1'b1, SDA_RAND, 1'b1, IDLE_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, OP_RSVD_6, 8'h00, 1'b0, SDA_RAND, 1'b1, IDLE_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, OP_RSVD_7, 8'hFF, 1'b1, SDA_RAND, 1'b1, IDLE_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 1'b1, START_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_WRITE, 8'h00, 1'b1, SDA_RAND, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_WAIT_ACK, 8'h00, 1'b0, SDA_LATE, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_READ, 8'h00, 1'b1, SDA_RAND, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b1, 8'd0, 8'd0, 1'b0, i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_WRITE, 8'h5A, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b1, 8'd255, 8'd255, 1'b0, i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b0, i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, OP_RSVD_7, 8'hFF, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b1, 8'd1, 8'd1, 1'b0, i2cmbe_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0, NO_PINS},
      '{1'b0, 8'd0, 8'd0, 1'b1, i2cmbe_pkg::OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH, 1'b0, NO_PINS}
   };

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   i2cmbe_req_if req_bus ();
   i2cmbe_rsp_if rsp_bus ();

   i2c_master_byte_engine_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [7:0]    cfg_half_period;
   logic [7:0]    cfg_ack_timeout;
   bus_phase_type bus_phase;
   logic [3:0]    bit_cnt;
   logic [7:0]    shifter;
   logic [7:0]    hold_cnt;
   logic [7:0]    poll_cnt;
   logic          ack_sel;
   logic          err_flag;
   logic          pin_scl;
   logic          pin_sda;
   logic          pin_drive;
   logic [7:0]    rx_hold;

   pins_type     expected_pins_q [$];
   sda_mode_type sda_mode;
   int           send_idle_pct;
   int           stall_pct;
   int           holds_asked;
   int           holds_served;
   int           hold_left;
   int           cycles;
   int           mismatches;
   int           ticks_sent;
   int           cmds_taken;
   int           reads_done;
   int           ack_timeouts;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic reset_predictor();
      cfg_half_period = i2cmbe_pkg::HALF_PERIOD_RESET;
      cfg_ack_timeout = i2cmbe_pkg::ACK_TIMEOUT_RESET;
      bus_phase = BP_IDLE;
      bit_cnt   = '0;
      shifter   = '0;
      hold_cnt  = '0;
      poll_cnt  = '0;
      ack_sel   = 1'b0;
      err_flag  = 1'b0;
      pin_scl   = 1'b1;
      pin_sda   = 1'b1;
      pin_drive = 1'b1;
      rx_hold   = '0;
   endtask

   // counts one tick of the current phase; zero half period acts as one
   function automatic bit phase_over();
      int span;
      int next;
      span = (cfg_half_period == 0) ? 1 : int'(cfg_half_period);
      next = int'(hold_cnt) + 1;
      if (next >= span) begin
         hold_cnt = '0;
         return 1'b1;
      end
      hold_cnt = 8'(next);
      return 1'b0;
   endfunction

   function automatic void shift_out_bit();
      pin_sda = (shifter & i2cmbe_pkg::MSB_MASK) != 0;
      shifter = shifter << 1;
   endfunction

   task automatic advance_bus(input tick_type t, output pins_type r);
      logic done;
      done = 1'b0;
      case (bus_phase)
         BP_IDLE: begin
            if (t.cmd_valid && t.operation <= i2cmbe_pkg::OP_WAIT_ACK) begin
               cmds_taken++;
               bit_cnt  = '0;
               hold_cnt = '0;
               poll_cnt = '0;
               case (t.operation)
                  i2cmbe_pkg::OP_START: begin
                     pin_drive = 1'b1; pin_sda = 1'b1; pin_scl = 1'b1;
                     bus_phase = BP_START_A;
                  end
                  i2cmbe_pkg::OP_STOP: begin
                     pin_drive = 1'b1; pin_scl = 1'b0; pin_sda = 1'b0;
                     bus_phase = BP_STOP_A;
                  end
                  i2cmbe_pkg::OP_WRITE: begin
                     pin_drive = 1'b1;
                     shifter   = t.tx_byte;
                     shift_out_bit();
                     bus_phase = BP_WR_DATA;
                  end
                  i2cmbe_pkg::OP_READ: begin
                     ack_sel   = t.send_ack;
                     pin_drive = 1'b0; pin_scl = 1'b0;
                     shifter   = '0;
                     bus_phase = BP_RD_LOW;
                  end
                  default: begin
                     err_flag  = 1'b0;
                     pin_drive = 1'b0; pin_sda = 1'b1;
                     bus_phase = BP_WA_ARM;
                  end
               endcase
            end
         end
         BP_START_A: if (phase_over()) begin pin_sda = 1'b0; bus_phase = BP_START_B; end
         BP_START_B: if (phase_over()) begin
            pin_scl = 1'b0; done = 1'b1; bus_phase = BP_IDLE;
         end
         BP_STOP_A: if (phase_over()) begin pin_scl = 1'b1; bus_phase = BP_STOP_B; end
         BP_STOP_B: if (phase_over()) begin pin_sda = 1'b1; bus_phase = BP_STOP_C; end
         BP_STOP_C: if (phase_over()) begin done = 1'b1; bus_phase = BP_IDLE; end
         BP_WR_DATA: if (phase_over()) begin pin_scl = 1'b1; bus_phase = BP_WR_HIGH; end
         BP_WR_HIGH: if (phase_over()) begin pin_scl = 1'b0; bus_phase = BP_WR_LOW; end
         BP_WR_LOW: if (phase_over()) begin
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt < i2cmbe_pkg::BITS_PER_BYTE) begin
               shift_out_bit();
               bus_phase = BP_WR_DATA;
            end else begin
               done = 1'b1;
               bus_phase = BP_IDLE;
            end
         end
         // SDA is sampled on the tick SCL rises
         BP_RD_LOW: if (phase_over()) begin
            pin_scl   = 1'b1;
            shifter   = {shifter[6:0], t.sda_in};
            bus_phase = BP_RD_HIGH;
         end
         BP_RD_HIGH: if (phase_over()) begin
            bit_cnt = bit_cnt + 1'b1;
            pin_scl = 1'b0;
            if (bit_cnt < i2cmbe_pkg::BITS_PER_BYTE) begin
               bus_phase = BP_RD_LOW;
            end else begin
               rx_hold   = shifter;
               reads_done++;
               pin_drive = 1'b1;
               pin_sda   = !ack_sel;
               bus_phase = BP_ACK_LOW;
            end
         end
         BP_ACK_LOW: if (phase_over()) begin pin_scl = 1'b1; bus_phase = BP_ACK_HIGH; end
         BP_ACK_HIGH: if (phase_over()) begin
            pin_scl = 1'b0; done = 1'b1; bus_phase = BP_IDLE;
         end
         BP_WA_ARM: if (phase_over()) begin pin_scl = 1'b1; bus_phase = BP_WA_HIGH; end
         BP_WA_HIGH: if (phase_over()) begin poll_cnt = '0; bus_phase = BP_WA_POLL; end
         BP_WA_POLL: begin
            if (!t.sda_in) begin
               pin_scl   = 1'b0;
               hold_cnt  = '0;
               bus_phase = BP_WA_TAIL;
            end else if (poll_cnt >= cfg_ack_timeout) begin
               // no acknowledge: flag it and fall into the stop sequence
               err_flag  = 1'b1;
               ack_timeouts++;
               pin_drive = 1'b1; pin_scl = 1'b0; pin_sda = 1'b0;
               hold_cnt  = '0;
               bus_phase = BP_STOP_A;
            end else begin
               poll_cnt = poll_cnt + 1'b1;
            end
         end
         BP_WA_TAIL: if (phase_over()) begin done = 1'b1; bus_phase = BP_IDLE; end
         default: bus_phase = BP_IDLE;
      endcase
      r.scl   = pin_scl;
      r.sda   = pin_sda;
      r.drive = pin_drive;
      r.ready = (bus_phase == BP_IDLE);
      r.done  = done;
      r.rx    = rx_hold;
      r.err   = err_flag;
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      pins_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pins_q.size() == 0) begin
            $error("response transfer with no tick outstanding");
            mismatches++;
         end else begin
            want = expected_pins_q.pop_front();
            check_field("scl_out",   want.scl,   rsp_bus.scl_out);
            check_field("sda_out",   want.sda,   rsp_bus.sda_out);
            check_field("sda_drive", want.drive, rsp_bus.sda_drive);
            check_field("ready_res", want.ready, rsp_bus.ready_res);
            check_field("done_res",  want.done,  rsp_bus.done_res);
            check_field("rx_byte",   want.rx,    rsp_bus.rx_byte);
            check_field("ack_error", want.err,   rsp_bus.ack_error);
         end
      end
   end

   // response side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (holds_served != holds_asked) begin
         hold_left = HOLD_LEN;
         holds_served++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic slave_sda();
      case (sda_mode)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         SDA_LATE: return ($urandom_range(5) != 0);
         default:  return 1'($urandom_range(1));
      endcase
   endfunction

   task automatic send_tick(input tick_type t, input logic typed, input pins_type want);
      pins_type got;
      bit       offered;
      offered = 1'b0;
      while (!offered) begin
         @(negedge clock);
         if ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid     <= 1'b1;
            req_bus.cmd_valid <= t.cmd_valid;
            req_bus.operation <= t.operation;
            req_bus.tx_byte   <= t.tx_byte;
            req_bus.send_ack  <= t.send_ack;
            req_bus.sda_in    <= t.sda_in;
            offered = 1'b1;
         end
      end
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      advance_bus(t, got);
      expected_pins_q.push_back(typed ? want : got);
      ticks_sent++;
   endtask

   // issue one command tick, then tick the bus until the engine is idle again;
   // the filler ticks carry random commands that a busy engine must ignore
   task automatic run_cmd(input tick_type cmd, input sda_mode_type mode,
                          input logic typed = 1'b0, input pins_type want = '0);
      tick_type fill;
      sda_mode = mode;
      cmd.sda_in = slave_sda();
      send_tick(cmd, typed, want);
      while (bus_phase != BP_IDLE) begin
         fill.cmd_valid = ($urandom_range(3) == 0);
         fill.operation = 3'($urandom_range(7));
         fill.tx_byte   = 8'($urandom);
         fill.send_ack  = 1'($urandom_range(1));
         fill.sda_in    = slave_sda();
         send_tick(fill, 1'b0, NO_PINS);
      end
   endtask

   function automatic tick_type mk_cmd(input logic [2:0] op, input logic [7:0] tx,
                                       input logic sack);
      return '{cmd_valid: 1'b1, operation: op, tx_byte: tx, send_ack: sack, sda_in: 1'b0};
   endfunction

   function automatic sda_mode_type pick_ack_mode();
      int r;
      r = $urandom_range(9);
      if (r == 0) return SDA_HIGH;
      if (r < 5) return SDA_LATE;
      return SDA_LOW;
   endfunction

   task automatic csr_write(input i2cmbe_pkg::reg_index_type idx, input logic [7:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'h0, val};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == i2cmbe_pkg::REG_HALF_PERIOD) cfg_half_period = val;
      else cfg_ack_timeout = val;
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field(idx == i2cmbe_pkg::REG_HALF_PERIOD ? "half_period" : "ack_timeout", val,
                  csr_prdata[7:0]);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_quiet();
      int waited;
      waited = 0;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_pins_q.size() != 0 && waited < DRAIN_MAX) begin
         @(posedge clock);
         waited++;
      end
      if (expected_pins_q.size() != 0) begin
         $error("%0d expected ticks never came back", expected_pins_q.size());
         mismatches += expected_pins_q.size();
         expected_pins_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_timing(input logic [7:0] hp, input logic [7:0] at);
      wait_quiet();
      csr_write(i2cmbe_pkg::REG_HALF_PERIOD, hp);
      csr_write(i2cmbe_pkg::REG_ACK_TIMEOUT, at);
   endtask

   // mostly well-formed transactions with random content, some loose commands
   task automatic run_traffic(input int n_ticks);
      int       stop_at;
      tick_type t;
      stop_at = ticks_sent + n_ticks;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(99) < 85) begin
            run_cmd(mk_cmd(i2cmbe_pkg::OP_START, 8'($urandom), 1'b0), SDA_RAND);
            run_cmd(mk_cmd(i2cmbe_pkg::OP_WRITE, 8'($urandom), 1'($urandom_range(1))),
                    SDA_RAND);
            run_cmd(mk_cmd(i2cmbe_pkg::OP_WAIT_ACK, 8'($urandom), 1'b0), pick_ack_mode());
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(1) == 0) begin
                  run_cmd(mk_cmd(i2cmbe_pkg::OP_WRITE, 8'($urandom), 1'b0), SDA_RAND);
                  run_cmd(mk_cmd(i2cmbe_pkg::OP_WAIT_ACK, 8'h00, 1'b0), pick_ack_mode());
               end else begin
                  run_cmd(mk_cmd(i2cmbe_pkg::OP_READ, 8'($urandom), 1'($urandom_range(1))),
                          SDA_RAND);
               end
            end
            run_cmd(mk_cmd(i2cmbe_pkg::OP_STOP, 8'($urandom), 1'b0), SDA_RAND);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               t = mk_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
               t.cmd_valid = ($urandom_range(3) != 0);
               run_cmd(t, SDA_RAND);
            end
         end
         repeat ($urandom_range(2)) run_cmd('0, SDA_RAND);
      end
   endtask

   initial begin
      dir_row_type row;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd_valid = 1'b0;
      req_bus.operation = i2cmbe_pkg::OP_START;
      req_bus.tx_byte   = 8'h00;
      req_bus.send_ack  = 1'b0;
      req_bus.sda_in    = 1'b1;
      rsp_bus.ready     = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      holds_asked       = 0;
      holds_served      = 0;
      hold_left         = 0;
      cycles            = 0;
      mismatches        = 0;
      ticks_sent        = 0;
      cmds_taken        = 0;
      reads_done        = 0;
      ack_timeouts      = 0;
      sda_mode          = SDA_RAND;
      reset_predictor();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         row = directed_rows[i];
         if (row.cfg) begin
            set_timing(row.hp, row.at);
         end else begin
            run_cmd('{cmd_valid: row.cmd_valid, operation: row.op, tx_byte: row.tx,
                      send_ack: row.sack, sda_in: 1'b0}, row.mode, row.typed, row.want);
         end
      end

      set_timing(8'd1, 8'd3);
      run_traffic(200);

      set_timing(8'd2, 8'd1);
      send_idle_pct = 70;
      run_traffic(190);

      send_idle_pct = 0;
      set_timing(8'd3, 8'd60);
      stall_pct = 70;
      run_traffic(190);

      stall_pct = 0;
      set_timing(8'd1, 8'd8);
      send_idle_pct = 19;
      stall_pct = 19;
      holds_asked++;
      run_traffic(190);

      wait_quiet();
      $display("checked %0d bus ticks: %0d commands taken, %0d bytes read, %0d ack timeouts",
               ticks_sent, cmds_taken, reads_done, ack_timeouts);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
design/i2cmbe_pkg.sv
design/i2cmbe_req_if.sv
design/i2cmbe_rsp_if.sv
design/i2cmbe_front.sv
design/i2cmbe_queue.sv
design/i2cmbe_back.sv
design/i2cmbe_front_back_note_placeholder.sv
design/i2c_master_byte_engine_core.sv
tb/sv/i2c_master_byte_engine_core_tb.sv
